### rtl/osma_pkg.sv
`default_nettype none
package osma_pkg;

    localparam int DIM_W   = 11;
    localparam int COEF_W  = 32;
    localparam int DRIFT_W = 24;
    localparam int IDX_W   = 20;
    localparam int WGT_W   = 48;
    localparam int CFG_A_W = 3;

    // drift (Q12.12) times coefficient (Q16.16) lands in Q.28
    localparam int Q_SHIFT = 12;
    localparam int PROD_W  = COEF_W + 1 + DRIFT_W;
    localparam int ACC_W   = 62;

    localparam logic [CFG_A_W-1:0] CFG_GRID_ROWS = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_GRID_COLS = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_COEF_RX   = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_COEF_RY   = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_COEF_RXX  = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_COEF_RYY  = 3'd5;

    localparam logic [DIM_W-1:0]  RST_GRID = 11'd256;
    localparam logic [COEF_W-1:0] RST_R    = 32'd32768;
    localparam logic [COEF_W-1:0] RST_RR   = 32'd65536;

    // entry order within one pixel: centre, right, left, bottom, top
    localparam int N_ENT = 5;
    localparam int ENT_C = 0;
    localparam int ENT_R = 1;
    localparam int ENT_L = 2;
    localparam int ENT_B = 3;
    localparam int ENT_T = 4;

    typedef struct packed {
        logic has_l;
        logic has_r;
        logic has_t;
        logic has_b;
        logic last_px;
    } t_nbr;

endpackage
`default_nettype wire

### rtl/osmosis_stencil_matrix_assembler_unit.sv
`default_nettype none
// Pipeline: an accepted word passes stage A, stage B, stage C (entry sequencer), then the output register.
// Throughput: one entry per cycle on the result channel while i_out_stall does not hold it; a pixel emits
// 1 to 5 entries (5 for an interior pixel), one at a time from the entry sequencer stage.
// A new input word is accepted every cycle while the pipeline has room.
// Reset (synchronous, active low) clears valids and pixel counters and loads register defaults.
module osmosis_stencil_matrix_assembler_unit
    import osma_pkg::*;
#(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,

    input  wire                         i_cfg_we,
    input  wire  [CFG_A_W-1:0]          i_cfg_index,
    input  wire  [COEF_W-1:0]           i_cfg_data,

    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  signed [DRIFT_W-1:0]   i_drift_x_left,
    input  wire  signed [DRIFT_W-1:0]   i_drift_x_here,
    input  wire  signed [DRIFT_W-1:0]   i_drift_y_up,
    input  wire  signed [DRIFT_W-1:0]   i_drift_y_here,

    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [IDX_W-1:0]            o_mat_row,
    output logic [IDX_W-1:0]            o_mat_col,
    output logic signed [WGT_W-1:0]     o_weight,
    output logic                        o_last_of_pixel,
    output logic                        o_end_of_image
);

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RDIM_W = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W = $clog2(MAX_COLS + 1);
    localparam int LIN_W  = ROW_W + CDIM_W + 1;

    // configuration
    logic [DIM_W-1:0]  r_grid_rows, r_grid_cols;
    logic [COEF_W-1:0] r_coef_rx, r_coef_ry, r_coef_rxx, r_coef_ryy;

    // pixel counters
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;

    // stage A: captured word
    logic                       r_a_vld;
    logic signed [DRIFT_W-1:0]  r_a_dxl, r_a_dxh, r_a_dyu, r_a_dyh;
    logic [ROW_W-1:0]           r_a_row;
    logic [COL_W-1:0]           r_a_col;
    logic [CDIM_W-1:0]          r_a_cols;
    t_nbr                       r_a_nbr;

    // stage B: products and linear index
    logic                       r_b_vld;
    logic signed [PROD_W-1:0]   r_b_pl, r_b_ph, r_b_pu, r_b_pd;
    logic [IDX_W-1:0]           r_b_idx;
    logic [CDIM_W-1:0]          r_b_cols;
    t_nbr                       r_b_nbr;

    // stage C: weights and pending entry mask
    logic [N_ENT-1:0]           r_c_pend;
    logic signed [WGT_W-1:0]    r_c_wc, r_c_wr, r_c_wl, r_c_wb, r_c_wt;
    logic [IDX_W-1:0]           r_c_idx;
    logic [CDIM_W-1:0]          r_c_cols;
    logic                       r_c_last_px;

    // output register
    logic                       r_o_vld;
    logic [IDX_W-1:0]           r_o_row, r_o_col;
    logic signed [WGT_W-1:0]    r_o_wgt;
    logic                       r_o_lop, r_o_eoi;

    // effective dimensions
    logic [RDIM_W-1:0] rows_eff;
    logic [CDIM_W-1:0] cols_eff;
    logic [ROW_W-1:0]  cur_row, n_row;
    logic [COL_W-1:0]  cur_col, n_col;
    logic [RDIM_W:0]   row_inc;
    logic [CDIM_W:0]   col_inc;
    t_nbr              cur_nbr;

    always_comb begin
        if (r_grid_rows == '0) begin
            rows_eff = RDIM_W'(1);
        end else if (32'(r_grid_rows) > 32'(MAX_ROWS)) begin
            rows_eff = RDIM_W'(MAX_ROWS);
        end else begin
            rows_eff = RDIM_W'(r_grid_rows);
        end
        if (r_grid_cols == '0) begin
            cols_eff = CDIM_W'(1);
        end else if (32'(r_grid_cols) > 32'(MAX_COLS)) begin
            cols_eff = CDIM_W'(MAX_COLS);
        end else begin
            cols_eff = CDIM_W'(r_grid_cols);
        end
    end

    // counters restart when the grid shrank below them
    always_comb begin
        cur_row = (32'(r_row) >= 32'(rows_eff)) ? '0 : r_row;
        cur_col = (32'(r_col) >= 32'(cols_eff)) ? '0 : r_col;
        row_inc = (RDIM_W + 1)'(cur_row) + (RDIM_W + 1)'(1);
        col_inc = (CDIM_W + 1)'(cur_col) + (CDIM_W + 1)'(1);

        cur_nbr.has_l   = (cur_col != '0);
        cur_nbr.has_r   = (col_inc < (CDIM_W + 1)'(cols_eff));
        cur_nbr.has_t   = (cur_row != '0);
        cur_nbr.has_b   = (row_inc < (RDIM_W + 1)'(rows_eff));
        cur_nbr.last_px = !cur_nbr.has_b && !cur_nbr.has_r;

        if (cur_nbr.has_b) begin
            n_row = ROW_W'(row_inc);
            n_col = cur_col;
        end else begin
            n_row = '0;
            n_col = cur_nbr.has_r ? COL_W'(col_inc) : '0;
        end
    end

    // handshake chain
    logic             out_ready, emit, last_ent, c_free, b_free, a_free, in_acc;
    logic [N_ENT-1:0] sel;

    assign sel       = r_c_pend & (~r_c_pend + N_ENT'(1));
    assign last_ent  = ((r_c_pend & ~sel) == '0);
    assign out_ready = !r_o_vld || !i_out_stall;
    assign emit      = (r_c_pend != '0) && out_ready;
    assign c_free    = (r_c_pend == '0) || (emit && last_ent);
    assign b_free    = !r_b_vld || c_free;
    assign a_free    = !r_a_vld || b_free;
    assign in_acc    = i_in_valid && a_free;
    assign o_in_stall = !a_free;

    // stage B arithmetic
    logic [LIN_W-1:0] lin;
    assign lin = LIN_W'(r_a_row) * LIN_W'(r_a_cols) + LIN_W'(r_a_col);

    // stage C arithmetic, exact in Q.28
    logic signed [ACC_W-1:0] rxx_q, ryy_q, pl, ph, pu, pd;
    logic signed [ACC_W-1:0] wl, wr, wt, wb, wc;
    logic signed [ACC_W-1:0] cl, cr, ct, cb;

    always_comb begin
        rxx_q = $signed(ACC_W'({r_coef_rxx, {Q_SHIFT{1'b0}}}));
        ryy_q = $signed(ACC_W'({r_coef_ryy, {Q_SHIFT{1'b0}}}));
        pl = ACC_W'(r_b_pl);
        ph = ACC_W'(r_b_ph);
        pu = ACC_W'(r_b_pu);
        pd = ACC_W'(r_b_pd);
        wl = rxx_q + pl;
        wr = rxx_q - ph;
        wt = ryy_q + pu;
        wb = ryy_q - pd;
        // reflected neighbours fold into the centre: each side's share of the
        // centre is picked per side, then (left + top) - (right + bottom) is formed as a tree
        cl = r_b_nbr.has_l ? (pl - rxx_q) : (pl <<< 1);
        cr = r_b_nbr.has_r ? (ph + rxx_q) : (ph <<< 1);
        ct = r_b_nbr.has_t ? (pu - ryy_q) : (pu <<< 1);
        cb = r_b_nbr.has_b ? (pd + ryy_q) : (pd <<< 1);
        wc = (cl + ct) - (cr + cb);
    end

    // entry select
    logic [IDX_W-1:0]        ent_col;
    logic signed [WGT_W-1:0] ent_wgt;

    always_comb begin
        if (sel[ENT_C]) begin
            ent_col = r_c_idx;
            ent_wgt = r_c_wc;
        end else if (sel[ENT_R]) begin
            ent_col = r_c_idx + IDX_W'(1);
            ent_wgt = r_c_wr;
        end else if (sel[ENT_L]) begin
            ent_col = r_c_idx - IDX_W'(1);
            ent_wgt = r_c_wl;
        end else if (sel[ENT_B]) begin
            ent_col = r_c_idx + IDX_W'(r_c_cols);
            ent_wgt = r_c_wb;
        end else begin
            ent_col = r_c_idx - IDX_W'(r_c_cols);
            ent_wgt = r_c_wt;
        end
    end

    logic [N_ENT-1:0] n_c_pend;
    always_comb begin
        n_c_pend = r_c_pend;
        if (c_free) begin
            n_c_pend = '0;
            if (r_b_vld) begin
                n_c_pend[ENT_C] = 1'b1;
                n_c_pend[ENT_R] = r_b_nbr.has_r;
                n_c_pend[ENT_L] = r_b_nbr.has_l;
                n_c_pend[ENT_B] = r_b_nbr.has_b;
                n_c_pend[ENT_T] = r_b_nbr.has_t;
            end
        end else if (emit) begin
            n_c_pend = r_c_pend & ~sel;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= RST_GRID;
            r_grid_cols <= RST_GRID;
            r_coef_rx   <= RST_R;
            r_coef_ry   <= RST_R;
            r_coef_rxx  <= RST_RR;
            r_coef_ryy  <= RST_RR;
            r_row       <= '0;
            r_col       <= '0;
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_pend    <= '0;
            r_o_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_ROWS: r_grid_rows <= i_cfg_data[DIM_W-1:0];
                    CFG_GRID_COLS: r_grid_cols <= i_cfg_data[DIM_W-1:0];
                    CFG_COEF_RX:   r_coef_rx   <= i_cfg_data;
                    CFG_COEF_RY:   r_coef_ry   <= i_cfg_data;
                    CFG_COEF_RXX:  r_coef_rxx  <= i_cfg_data;
                    CFG_COEF_RYY:  r_coef_ryy  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (a_free) r_a_vld <= i_in_valid;
            if (b_free) r_b_vld <= r_a_vld;
            r_c_pend <= n_c_pend;
            if (out_ready) r_o_vld <= emit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_dxl  <= i_drift_x_left;
            r_a_dxh  <= i_drift_x_here;
            r_a_dyu  <= i_drift_y_up;
            r_a_dyh  <= i_drift_y_here;
            r_a_row  <= cur_row;
            r_a_col  <= cur_col;
            r_a_cols <= cols_eff;
            r_a_nbr  <= cur_nbr;
        end
        if (r_a_vld && b_free) begin
            r_b_pl   <= $signed(PROD_W'({1'b0, r_coef_rx})) * PROD_W'(r_a_dxl);
            r_b_ph   <= $signed(PROD_W'({1'b0, r_coef_rx})) * PROD_W'(r_a_dxh);
            r_b_pu   <= $signed(PROD_W'({1'b0, r_coef_ry})) * PROD_W'(r_a_dyu);
            r_b_pd   <= $signed(PROD_W'({1'b0, r_coef_ry})) * PROD_W'(r_a_dyh);
            r_b_idx  <= IDX_W'(lin);
            r_b_cols <= r_a_cols;
            r_b_nbr  <= r_a_nbr;
        end
        if (r_b_vld && c_free) begin
            // floor to Q.16
            r_c_wc      <= wc[WGT_W+Q_SHIFT-1:Q_SHIFT];
            r_c_wr      <= wr[WGT_W+Q_SHIFT-1:Q_SHIFT];
            r_c_wl      <= wl[WGT_W+Q_SHIFT-1:Q_SHIFT];
            r_c_wb      <= wb[WGT_W+Q_SHIFT-1:Q_SHIFT];
            r_c_wt      <= wt[WGT_W+Q_SHIFT-1:Q_SHIFT];
            r_c_idx     <= r_b_idx;
            r_c_cols    <= r_b_cols;
            r_c_last_px <= r_b_nbr.last_px;
        end
        if (emit) begin
            r_o_row <= r_c_idx;
            r_o_col <= ent_col;
            r_o_wgt <= ent_wgt;
            r_o_lop <= last_ent;
            r_o_eoi <= last_ent && r_c_last_px;
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_mat_row       = r_o_row;
    assign o_mat_col       = r_o_col;
    assign o_weight        = r_o_wgt;
    assign o_last_of_pixel = r_o_lop;
    assign o_end_of_image  = r_o_eoi;

endmodule
`default_nettype wire
